// File: src/ubxfr_pkg.sv
package ubxfr_pkg;

  // fixed field widths
  localparam int ByteW = 8;
  localparam int IdxW  = 10;
  localparam int LenW  = 16;

  // header bytes counted against the frame limit besides the payload
  localparam int unsigned HeaderBytes = 4;

  // configuration port
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 3;
  localparam logic RegSyncFirst  = 1'b0;
  localparam logic RegSyncSecond = 1'b1;
  localparam logic [ByteW-1:0] SyncFirstRst  = 8'd181;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'd98;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [IdxW-1:0]  byte_index;
    logic             frame_end;
    logic             frame_ok;
    logic [ByteW-1:0] msg_class;
    logic [ByteW-1:0] msg_id;
    logic [IdxW-1:0]  payload_length;
    logic             frame_error;
  } out_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
  } cfg_t;

endpackage

// File: src/ubxfr_stream_if.sv
interface ubxfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/ubxfr_cfg_regs.sv
module ubxfr_cfg_regs
  import ubxfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic             wr_en;
  logic             reg_sel;
  logic [ByteW-1:0] sync_first_q;
  logic [ByteW-1:0] sync_second_q;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else if (wr_en) begin
      if (reg_sel == RegSyncFirst) begin
        sync_first_q <= pwdata[ByteW-1:0];
      end else begin
        sync_second_q <= pwdata[ByteW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == RegSyncFirst) begin
      prdata[ByteW-1:0] = sync_first_q;
    end else begin
      prdata[ByteW-1:0] = sync_second_q;
    end
  end

  assign cfg_o.sync_first  = sync_first_q;
  assign cfg_o.sync_second = sync_second_q;

endmodule

// File: src/ubxfr_parser.sv
module ubxfr_parser
  import ubxfr_pkg::*;
#(
  parameter int MaxFrame = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output out_beat_t        res_o
);

  localparam int CntW = $clog2(MaxFrame - 3);
  localparam int CmpW = LenW + 1;

  localparam logic [3:0] PhHunt    = 4'd0;
  localparam logic [3:0] PhSync2   = 4'd1;
  localparam logic [3:0] PhClass   = 4'd2;
  localparam logic [3:0] PhId      = 4'd3;
  localparam logic [3:0] PhLen1    = 4'd4;
  localparam logic [3:0] PhLen2    = 4'd5;
  localparam logic [3:0] PhPayload = 4'd6;
  localparam logic [3:0] PhChk1    = 4'd7;
  localparam logic [3:0] PhChk2    = 4'd8;

  logic [3:0]       phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] class_q, class_d;
  logic [ByteW-1:0] id_q, id_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] sum_a_q, sum_a_d;
  logic [ByteW-1:0] sum_b_q, sum_b_d;
  logic             got_a_q, got_a_d;

  logic [ByteW-1:0] a_base, b_base, add_a, add_b;
  logic [CntW-1:0]  cnt_inc;
  logic             pay_last;
  logic             too_long;

  // fletcher step; the class byte starts both sums from zero
  assign a_base   = (phase_q == PhClass) ? '0 : sum_a_q;
  assign b_base   = (phase_q == PhClass) ? '0 : sum_b_q;
  assign add_a    = a_base + rx_byte_i;
  assign add_b    = b_base + add_a;
  assign cnt_inc  = cnt_q + 1'b1;
  assign pay_last = CmpW'(cnt_inc) >= CmpW'(len_q);
  assign too_long = (CmpW'({rx_byte_i, len_q[ByteW-1:0]}) + CmpW'(HeaderBytes))
                    > CmpW'(MaxFrame);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    got_a_d = got_a_q;
    res_o   = '0;
    case (phase_q)
      PhSync2: begin
        phase_d = (rx_byte_i == cfg_i.sync_second) ? PhClass : PhHunt;
      end
      PhClass: begin
        cnt_d   = '0;
        got_a_d = 1'b0;
        class_d = rx_byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = PhId;
      end
      PhId: begin
        id_d    = rx_byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = PhLen1;
      end
      PhLen1: begin
        len_d   = LenW'(rx_byte_i);
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = PhLen2;
      end
      PhLen2: begin
        len_d   = {rx_byte_i, len_q[ByteW-1:0]};
        sum_a_d = add_a;
        sum_b_d = add_b;
        if (too_long) begin
          res_o.frame_error = 1'b1;
          phase_d = PhHunt;
        end else if (len_d == '0) begin
          phase_d = PhChk1;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = rx_byte_i;
        res_o.byte_index    = IdxW'(cnt_q);
        cnt_d = cnt_inc;
        if (pay_last) begin
          phase_d = PhChk1;
        end
      end
      PhChk1: begin
        got_a_d = (rx_byte_i == sum_a_q);
        phase_d = PhChk2;
      end
      PhChk2: begin
        res_o.frame_end = 1'b1;
        res_o.frame_ok  = got_a_q & (rx_byte_i == sum_b_q);
        phase_d = PhHunt;
      end
      default: begin
        phase_d = (rx_byte_i == cfg_i.sync_first) ? PhSync2 : PhHunt;
      end
    endcase
    res_o.msg_class      = class_d;
    res_o.msg_id         = id_d;
    res_o.payload_length = len_d[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cnt_q   <= '0;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      got_a_q <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      got_a_q <= got_a_d;
    end
  end

  a_ok_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_o.frame_ok |-> res_o.frame_end)
    else $error("frame_ok without frame_end");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |-> $countones({res_o.payload_valid, res_o.frame_end,
                              res_o.frame_error}) <= 1)
    else $error("payload, end and error flags overlap");

  a_payload_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && phase_q == PhPayload && pay_last |=> phase_q == PhChk1)
    else $error("last payload byte did not move to checksum");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && phase_q == PhLen2 && !too_long && rx_byte_i == '0 &&
    len_q[ByteW-1:0] == '0 |=> phase_q == PhChk1)
    else $error("empty payload did not skip to checksum");

endmodule

// File: src/ubx_frame_receiver_core.sv
// channel   dir  payload                                   handshake
// in_if     in   rx_byte                                   valid/ready
// out_if    out  payload/index, frame_end/ok/error, header valid/ready
// apb       in   sync_first @0x0, sync_second @0x4         psel/penable, pready=1
//
// one byte in, one result out; sustained rate is one beat per cycle while out_if.ready stays high
// path: input register, then parse logic into the result register
// parser state advances only when the held byte moves into the result register
// a stalled result register holds and backs up the input register; in_if.ready
// stays high while the result register can drain in the same cycle
// reset clears all control and parser state; sync registers return to 0xb5/0x62
module ubx_frame_receiver_core
  import ubxfr_pkg::*;
#(
  parameter int MaxFrame = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ubxfr_stream_if.sink        in_if,
  ubxfr_stream_if.source      out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t      cfg;
  in_beat_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_beat_t res;
  out_beat_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic      in_take;

  // held byte moves on when the result register is empty or being drained
  assign advance    = in_valid_q & (~out_valid_q | out_if.ready);
  assign in_if.ready = ~in_valid_q | advance;
  assign in_take    = in_if.valid & in_if.ready;

  assign in_valid_d  = in_take | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_if.data;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  ubxfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // framing state machine and fletcher sums
  ubxfr_parser #(
    .MaxFrame (MaxFrame)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (in_q.rx_byte),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held input beat lost");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("parsed beat did not reach result register");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result beat changed");

endmodule
